// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands for the RTL. Every check samples on the rising
// edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, action codes and default sizes of the tone sequence player.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // Default sizes
    localparam int TSP_SEQ_DEPTH = 4;   // sequence entries, first one included
    localparam int TSP_GAP_TICKS = 30;  // silent ticks between sequence tones

    // Action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_TONE  = 2'd1;
    localparam logic [1:0] ACT_ENTRY = 2'd2;

    // One input item
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] tone_freq;
        logic [15:0] tone_duration;
        logic        first_entry;
    } tsp_item_t;

    // One result item
    typedef struct packed {
        logic        sounding;
        logic [15:0] sound_freq;
        logic [1:0]  queued_left;
    } tsp_result_t;

endpackage

// ===== rtl/tone_sequence_player_unit.sv =====
// ----------------------------------------------------------------------------
// tone_sequence_player_unit
// Buzzer tone sequencer: turns ticks, single tones and sequence entries into
// the frequency to drive on an external square-wave generator.
// ----------------------------------------------------------------------------
// Each input transfer is one action: a one-millisecond tick, a single tone or
// a sequence entry; each gives exactly one result transfer with the tone state
// after that action (sounding flag, driven frequency, queued tone count). An
// item is held in the input register, updates the sequencer state on its way
// into the output register and leaves from there as its result. One item
// per cycle is sustained as long as the output is not stalled, and the state
// updates once per item. The output register lets a new item be taken while
// a finished result still waits, and in_stall rises only when both registers
// are full and the output is stalled. A single tone cancels any sequence; a
// first entry sounds at once and up to SEQ_DEPTH-1 further entries queue
// behind it, with GAP_TICKS silent ticks between tones. Write cfg_data only
// while no item is in flight; writing 0 silences the output and drops the
// sequence, and while disabled every action is ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tone_sequence_player_unit
    import tsp_pkg::*;
#(
    parameter int SEQ_DEPTH = TSP_SEQ_DEPTH,
    parameter int GAP_TICKS = TSP_GAP_TICKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        cfg_write,
    input  logic        cfg_data,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] tone_freq,
    input  logic [15:0] tone_duration,
    input  logic        first_entry,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        sounding,
    output logic [15:0] sound_freq,
    output logic [1:0]  queued_left
);

    logic        s1_vld_reg, s1_vld_next;
    tsp_item_t   s1_item_reg;
    logic        out_vld_reg, out_vld_next;
    tsp_result_t out_res_reg;

    tsp_result_t core_res;
    logic        advance;
    logic        step_en;
    logic        in_xfer;

    // Output register frees up when empty or when its result transfers
    assign advance  = !out_vld_reg || !out_stall;
    // Process the held item as it moves into the output register
    assign step_en  = s1_vld_reg && advance;
    // Hold off new transfers only while the input register cannot drain
    assign in_stall = s1_vld_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    tsp_core #(
        .SEQ_DEPTH (SEQ_DEPTH),
        .GAP_TICKS (GAP_TICKS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .step_en   (step_en),
        .item      (s1_item_reg),
        .result    (core_res)
    );

    always_comb
    begin
        s1_vld_next  = in_stall ? s1_vld_reg : in_valid;
        out_vld_next = advance ? s1_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers: load on transfer, otherwise hold
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg.action        <= action;
            s1_item_reg.tone_freq     <= tone_freq;
            s1_item_reg.tone_duration <= tone_duration;
            s1_item_reg.first_entry   <= first_entry;
        end
        if (step_en)
        begin
            out_res_reg <= core_res;
        end
    end

    assign out_valid   = out_vld_reg;
    assign sounding    = out_res_reg.sounding;
    assign sound_freq  = out_res_reg.sound_freq;
    assign queued_left = out_res_reg.queued_left;

    // Checks
    `ASSERT_NEXT(a_step_fills_out, step_en, out_vld_reg, "processed item lost before output")
    `ASSERT_NEXT(a_s1_holds, s1_vld_reg && !advance,
        s1_vld_reg && $stable(s1_item_reg), "held input item changed while blocked")
    `ASSERT_SAME(a_silent_freq, out_valid && !sounding, sound_freq == 16'd0,
        "nonzero frequency reported while silent")
    `ASSERT_SAME(a_stall_full, in_stall, s1_vld_reg && out_vld_reg,
        "input stalled with a free register")

endmodule

// ===== rtl/tsp_queue.sv =====
// ----------------------------------------------------------------------------
// tsp_queue
// Small register file for queued sequence entries: one write port and one
// combinational read port.
// ----------------------------------------------------------------------------
module tsp_queue
    import tsp_pkg::*;
#(
    parameter int SEQ_DEPTH = TSP_SEQ_DEPTH,
    localparam int QIDX_W   = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [QIDX_W-1:0] wr_idx,
    input  logic [15:0]       wr_freq,
    input  logic [15:0]       wr_dur,
    input  logic [QIDX_W-1:0] rd_idx,
    output logic [15:0]       rd_freq,
    output logic [15:0]       rd_dur
);

    localparam int SLOTS = 2 ** QIDX_W;

    logic [15:0] freq_reg [SLOTS];
    logic [15:0] dur_reg  [SLOTS];

    // Slots are written before they are read; no reset needed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            freq_reg[wr_idx] <= wr_freq;
            dur_reg[wr_idx]  <= wr_dur;
        end
    end

    assign rd_freq = freq_reg[rd_idx];
    assign rd_dur  = dur_reg[rd_idx];

endmodule

// ===== rtl/tsp_core.sv =====
// ----------------------------------------------------------------------------
// tsp_core
// Sequencer state: enable flag, tone and gap countdowns, queue bookkeeping.
// Updates once per transfer or configuration write and forms the result from the updated state.
// ----------------------------------------------------------------------------
module tsp_core
    import tsp_pkg::*;
#(
    parameter int SEQ_DEPTH = TSP_SEQ_DEPTH,
    parameter int GAP_TICKS = TSP_GAP_TICKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        step_en,
    input  tsp_item_t   item,
    output tsp_result_t result
);

    localparam int QIDX_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int LEN_W  = $clog2(SEQ_DEPTH + 1);
    localparam int GAP_W  = $clog2(GAP_TICKS + 1);

    logic              enabled_reg,      enabled_next;
    logic [15:0]       tone_left_reg,    tone_left_next;
    logic              tone_timing_reg,  tone_timing_next;
    logic [GAP_W-1:0]  gap_left_reg,     gap_left_next;
    logic              gap_pending_reg,  gap_pending_next;
    logic [LEN_W-1:0]  queue_len_reg,    queue_len_next;
    logic [LEN_W-1:0]  queue_pos_reg,    queue_pos_next;
    logic [15:0]       cur_freq_reg,     cur_freq_next;

    logic              q_wr_en;
    logic [15:0]       q_rd_freq;
    logic [15:0]       q_rd_dur;
    logic [LEN_W-1:0]  left_diff;
    logic [LEN_W+1:0]  left_wide;

    tsp_queue #(
        .SEQ_DEPTH (SEQ_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_idx  (queue_len_reg[QIDX_W-1:0]),
        .wr_freq (item.tone_freq),
        .wr_dur  (item.tone_duration),
        .rd_idx  (queue_pos_reg[QIDX_W-1:0]),
        .rd_freq (q_rd_freq),
        .rd_dur  (q_rd_dur)
    );

    always_comb
    begin
        enabled_next     = enabled_reg;
        tone_left_next   = tone_left_reg;
        tone_timing_next = tone_timing_reg;
        gap_left_next    = gap_left_reg;
        gap_pending_next = gap_pending_reg;
        queue_len_next   = queue_len_reg;
        queue_pos_next   = queue_pos_reg;
        cur_freq_next    = cur_freq_reg;
        q_wr_en          = 1'b0;

        if (cfg_write)
        begin
            enabled_next = cfg_data;
            if (!cfg_data)
            begin
                tone_left_next   = '0;
                tone_timing_next = 1'b0;
                gap_left_next    = '0;
                gap_pending_next = 1'b0;
                queue_len_next   = '0;
                queue_pos_next   = '0;
                cur_freq_next    = '0;
            end
        end
        else if (step_en && enabled_reg)
        begin
            case (item.action)
                ACT_TICK:
                begin
                    if (tone_timing_reg)
                    begin
                        if (tone_left_reg <= 16'd1)
                        begin
                            tone_timing_next = 1'b0;
                            tone_left_next   = '0;
                            cur_freq_next    = '0;
                            if (queue_pos_reg < queue_len_reg)
                            begin
                                gap_pending_next = 1'b1;
                                gap_left_next    = GAP_W'(GAP_TICKS);
                            end
                        end
                        else
                        begin
                            tone_left_next = tone_left_reg - 16'd1;
                        end
                    end
                    else if (gap_pending_reg)
                    begin
                        if (gap_left_reg <= GAP_W'(1))
                        begin
                            gap_pending_next = 1'b0;
                            gap_left_next    = '0;
                            if ((queue_pos_reg < queue_len_reg) &&
                                (queue_pos_reg < LEN_W'(SEQ_DEPTH)))
                            begin
                                cur_freq_next    = q_rd_freq;
                                tone_left_next   = q_rd_dur;
                                tone_timing_next = 1'b1;
                                queue_pos_next   = queue_pos_reg + LEN_W'(1);
                            end
                        end
                        else
                        begin
                            gap_left_next = gap_left_reg - GAP_W'(1);
                        end
                    end
                end
                ACT_TONE:
                begin
                    // Single tone cancels the sequence and any gap
                    queue_len_next   = '0;
                    queue_pos_next   = '0;
                    gap_pending_next = 1'b0;
                    gap_left_next    = '0;
                    cur_freq_next    = item.tone_freq;
                    tone_left_next   = item.tone_duration;
                    tone_timing_next = 1'b1;
                end
                ACT_ENTRY:
                begin
                    if (item.first_entry)
                    begin
                        gap_pending_next = 1'b0;
                        gap_left_next    = '0;
                        cur_freq_next    = item.tone_freq;
                        tone_left_next   = item.tone_duration;
                        tone_timing_next = 1'b1;
                        queue_len_next   = LEN_W'(1);
                        queue_pos_next   = LEN_W'(1);
                    end
                    else if ((queue_len_reg != '0) &&
                             (queue_len_reg < LEN_W'(SEQ_DEPTH)))
                    begin
                        q_wr_en        = 1'b1;
                        queue_len_next = queue_len_reg + LEN_W'(1);
                    end
                end
                default:
                begin
                    // Unused action code: hold state
                end
            endcase
        end
    end

    // Result reflects the state after this transfer
    always_comb
    begin
        left_diff = (queue_pos_next < queue_len_next) ?
                    (queue_len_next - queue_pos_next) : '0;
        left_wide = (LEN_W + 2)'(left_diff);
        result.sounding    = enabled_next && tone_timing_next;
        result.sound_freq  = result.sounding ? cur_freq_next : 16'd0;
        result.queued_left = enabled_next ? left_wide[1:0] : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            tone_left_reg   <= '0;
            tone_timing_reg <= 1'b0;
            gap_left_reg    <= '0;
            gap_pending_reg <= 1'b0;
            queue_len_reg   <= '0;
            queue_pos_reg   <= '0;
            cur_freq_reg    <= '0;
        end
        else
        begin
            enabled_reg     <= enabled_next;
            tone_left_reg   <= tone_left_next;
            tone_timing_reg <= tone_timing_next;
            gap_left_reg    <= gap_left_next;
            gap_pending_reg <= gap_pending_next;
            queue_len_reg   <= queue_len_next;
            queue_pos_reg   <= queue_pos_next;
            cur_freq_reg    <= cur_freq_next;
        end
    end

endmodule

// ===== tb/tb_tone_sequence_player_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tone_sequence_player_unit
// Self-checking bench for the buzzer tone sequencer. A command-level mirror of
// the sequencer state predicts one tone state per accepted command. Every
// result transfer is compared field by field against the oldest prediction.
// Stimulus runs a short directed pass first, then randomized tick, tone and
// sequence traffic with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_tone_sequence_player_unit;

    import tsp_pkg::*;

    // Action code that the block must ignore
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int RANDOM_COMMANDS = 850;
    localparam int LONG_HOLD       = 120;     // cycles of the long result back-pressure
    localparam int DRAIN_CYCLES    = 8;       // settling cycles after the final drain
    localparam int CYCLE_LIMIT     = 600000;
    localparam int MAX_REPORTS     = 100;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the sequencer state and the queue of predicted
    // tone states, one per accepted command.
    // ------------------------------------------------------------------------
    class tone_scoreboard;
        bit          enabled;
        bit          tone_on;
        logic [15:0] tone_left;
        logic [15:0] freq_now;
        bit          gap_on;
        logic [4:0]  gap_left;
        logic [15:0] seq_freq [TSP_SEQ_DEPTH];
        logic [15:0] seq_dur  [TSP_SEQ_DEPTH];
        int unsigned seq_len;
        int unsigned seq_pos;

        tsp_result_t expected_states [$];

        int commands_taken;
        int ignored_items;
        int ticks;
        int single_tones;
        int entries;
        int gap_starts;
        int results_checked;
        int mismatches;

        function new();
            enabled = 1'b0;
            silence();
            foreach (seq_freq[i])
            begin
                seq_freq[i] = '0;
                seq_dur[i]  = '0;
            end
        endfunction

        function void silence();
            tone_on   = 1'b0;
            tone_left = '0;
            freq_now  = '0;
            gap_on    = 1'b0;
            gap_left  = '0;
            seq_len   = 0;
            seq_pos   = 0;
        endfunction

        // Writing 0 drops the tone, the gap and the whole sequence
        function void set_enabled(bit value);
            enabled = value;
            if (!value)
                silence();
        endfunction

        function void start_tone(logic [15:0] f, logic [15:0] d);
            freq_now  = f;
            tone_left = d;
            tone_on   = 1'b1;
        endfunction

        // One millisecond: run down the tone first, else the gap
        function void advance_tick();
            if (tone_on)
            begin
                if (tone_left <= 16'd1)
                begin
                    tone_on   = 1'b0;
                    tone_left = '0;
                    freq_now  = '0;
                    if (seq_pos < seq_len)
                    begin
                        gap_on   = 1'b1;
                        gap_left = 5'(TSP_GAP_TICKS);
                    end
                end
                else
                    tone_left = tone_left - 16'd1;
            end
            else if (gap_on)
            begin
                if (gap_left <= 5'd1)
                begin
                    gap_on   = 1'b0;
                    gap_left = '0;
                    if (seq_pos < seq_len && seq_pos < TSP_SEQ_DEPTH)
                    begin
                        start_tone(seq_freq[seq_pos], seq_dur[seq_pos]);
                        seq_pos++;
                        gap_starts++;
                    end
                end
                else
                    gap_left = gap_left - 5'd1;
            end
        endfunction

        // Note an accepted command and predict the tone state it leaves
        function void take_command(tsp_item_t cmd);
            tsp_result_t want;
            int unsigned waiting;
            if (!enabled || cmd.action == ACT_NONE)
                ignored_items++;
            else
                commands_taken++;
            if (enabled)
            begin
                case (cmd.action)
                    ACT_TICK:
                    begin
                        ticks++;
                        advance_tick();
                    end
                    ACT_TONE:
                    begin
                        single_tones++;
                        seq_len  = 0;
                        seq_pos  = 0;
                        gap_on   = 1'b0;
                        gap_left = '0;
                        start_tone(cmd.tone_freq, cmd.tone_duration);
                    end
                    ACT_ENTRY:
                    begin
                        entries++;
                        if (cmd.first_entry)
                        begin
                            gap_on   = 1'b0;
                            gap_left = '0;
                            start_tone(cmd.tone_freq, cmd.tone_duration);
                            seq_len  = 1;
                            seq_pos  = 1;
                        end
                        else if (seq_len >= 1 && seq_len < TSP_SEQ_DEPTH)
                        begin
                            seq_freq[seq_len] = cmd.tone_freq;
                            seq_dur[seq_len]  = cmd.tone_duration;
                            seq_len++;
                        end
                    end
                    default: ;
                endcase
            end
            waiting = (seq_pos < seq_len) ? seq_len - seq_pos : 0;
            want.sounding    = enabled && tone_on;
            want.sound_freq  = want.sounding ? freq_now : 16'h0000;
            want.queued_left = enabled ? 2'(waiting) : 2'd0;
            expected_states.push_back(want);
        endfunction

        task report(string field, logic [15:0] want, logic [15:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] result %0d: %s expected %0h got %0h",
                         $time, results_checked, field, want, got);
        endtask

        // Compare one result transfer against the oldest prediction
        task check_tone_state(tsp_result_t got);
            tsp_result_t want;
            results_checked++;
            if (expected_states.size() == 0)
            begin
                report("unexpected result, sound_freq", 16'h0000, got.sound_freq);
                return;
            end
            want = expected_states.pop_front();
            if (got.sounding !== want.sounding)
                report("sounding", 16'(want.sounding), 16'(got.sounding));
            if (got.sound_freq !== want.sound_freq)
                report("sound_freq", want.sound_freq, got.sound_freq);
            if (got.queued_left !== want.queued_left)
                report("queued_left", 16'(want.queued_left), 16'(got.queued_left));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [15:0] tone_freq;
    logic [15:0] tone_duration;
    logic        first_entry;
    logic        out_valid;
    logic        out_stall;
    logic        sounding;
    logic [15:0] sound_freq;
    logic [1:0]  queued_left;

    tone_scoreboard tracker = new();
    bit             sink_holding = 1'b0;   // long back-pressure in progress
    bit             sender_eager = 1'b0;   // stretch with no input idling
    int unsigned    cycle_count = 0;

    tone_sequence_player_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .tone_freq     (tone_freq),
        .tone_duration (tone_duration),
        .first_entry   (first_entry),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sounding      (sounding),
        .sound_freq    (sound_freq),
        .queued_left   (queued_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run; the limit sits far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, tracker.expected_states.size());
            $display("FAIL tone_sequence_player_unit");
            $finish;
        end
    end

    // Sample result transfers at the rising edge, with pre-edge values
    always @(posedge clk)
    begin
        tsp_result_t got;
        got.sounding    = sounding;
        got.sound_freq  = sound_freq;
        got.queued_left = queued_left;
        if (rst_n && out_valid && !out_stall)
            tracker.check_tone_state(got);
    end

    // ------------------------------------------------------------------------
    // Result side: alternate flow and stall runs of random length, mostly
    // short. Twice in the run, stall the output for a long hold (LONG_HOLD) so
    // the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int  run;
        bit  level;
        int  hold_mark;
        int  r;
        out_stall = 1'b0;
        run       = 0;
        level     = 1'b0;
        hold_mark = 120;
        forever
        begin
            @(negedge clk);
            if (run == 0)
            begin
                r = int'($urandom_range(0, 99));
                if (tracker.results_checked >= hold_mark && hold_mark < 1000)
                begin
                    level        = 1'b1;
                    run          = LONG_HOLD;
                    sink_holding = 1'b1;
                    hold_mark   += 480;
                end
                else
                begin
                    sink_holding = 1'b0;
                    level        = !level;
                    if (level)
                        run = (r < 70) ? int'($urandom_range(1, 2)) :
                              (r < 95) ? int'($urandom_range(3, 8)) :
                                         int'($urandom_range(20, 50));
                    else
                        run = (r < 80) ? int'($urandom_range(1, 10)) :
                                         int'($urandom_range(30, 150));
                end
            end
            out_stall <= level;
            run--;
        end
    end

    // ------------------------------------------------------------------------
    // Input side helpers
    // ------------------------------------------------------------------------
    function automatic tsp_item_t make_item(logic [1:0] act, logic [15:0] f,
                                            logic [15:0] d, logic first);
        tsp_item_t cmd;
        cmd.action        = act;
        cmd.tone_freq     = f;
        cmd.tone_duration = d;
        cmd.first_entry   = first;
        return cmd;
    endfunction

    // Tick with random don't-care fields, so every payload bit toggles
    function automatic tsp_item_t random_tick();
        return make_item(ACT_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    function automatic tsp_item_t random_noise();
        return make_item(2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    function automatic logic [15:0] pick_freq();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly short tones so sequences play out; a few full-range durations
    function automatic logic [15:0] pick_duration();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 12)
            return 16'd0;
        else if (r < 24)
            return 16'd1;
        else if (r < 88)
            return 16'($urandom_range(2, 12));
        else if (r < 96)
            return 16'($urandom_range(13, 200));
        else
            return 16'($urandom);
    endfunction

    function automatic int pick_gap();
        int r;
        if (sink_holding || sender_eager)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        else if (r < 85)
            return int'($urandom_range(1, 3));
        else if (r < 97)
            return int'($urandom_range(4, 10));
        else
            return int'($urandom_range(20, 60));
    endfunction

    // Offer one command after a random gap and hold it until its transfer.
    // Valid stays high on return; a drain, or the next call's random gap, lowers it.
    task automatic send_item(input tsp_item_t cmd);
        int idle;
        idle = pick_gap();
        @(negedge clk);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= cmd.action;
        tone_freq     <= cmd.tone_freq;
        tone_duration <= cmd.tone_duration;
        first_entry   <= cmd.first_entry;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_command(cmd);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(random_tick());
    endtask

    // Stop offering, wait for every predicted result, then let the pipe settle
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.expected_states.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the enable register; call only with the block idle
    task automatic write_enable(input bit value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        tracker.set_enabled(value);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int base;
        int r;
        int n;

        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_data      = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_TICK;
        tone_freq     = '0;
        tone_duration = '0;
        first_entry   = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Disabled after reset: every command is dropped, output stays silent
        send_item(make_item(ACT_TONE, 16'd1000, 16'd50, 1'b0));
        send_item(make_item(ACT_ENTRY, 16'd2000, 16'd5, 1'b1));
        send_item(random_tick());
        wait_for_drain();
        write_enable(1'b1);

        // Field extremes, zero and unit durations
        send_item(make_item(ACT_TONE, 16'hFFFF, 16'd0, 1'b0));
        send_item(random_tick());
        send_item(make_item(ACT_TONE, 16'h0000, 16'd1, 1'b1));
        // Later entry with no sequence behind it: dropped
        send_item(make_item(ACT_ENTRY, 16'h1111, 16'd3, 1'b0));
        send_item(random_tick());
        // Fill the sequence, then one entry too many
        send_item(make_item(ACT_ENTRY, 16'h1234, 16'd2, 1'b1));
        send_item(make_item(ACT_ENTRY, 16'hFFFF, 16'hFFFF, 1'b0));
        send_item(make_item(ACT_ENTRY, 16'h0000, 16'h0000, 1'b0));
        send_item(make_item(ACT_ENTRY, 16'hAAAA, 16'h5555, 1'b0));
        send_item(make_item(ACT_ENTRY, 16'h5555, 16'hAAAA, 1'b0));
        // Unknown action changes nothing
        send_item(make_item(ACT_NONE, 16'hFFFF, 16'hFFFF, 1'b1));
        // Tone ends with entries queued: gap opens
        send_ticks(3);
        // Single tone cancels the sequence and the gap
        send_item(make_item(ACT_TONE, 16'd440, 16'd3, 1'b0));
        send_ticks(3);
        // Entry appended after the sequence went idle: stays queued, never plays
        send_item(make_item(ACT_ENTRY, 16'd777, 16'd0, 1'b1));
        send_item(random_tick());
        send_item(make_item(ACT_ENTRY, 16'd888, 16'd4, 1'b0));
        send_ticks(2);
        wait_for_drain();
        write_enable(1'b0);
        wait_for_drain();
        write_enable(1'b1);

        // Random traffic, mostly well-formed sequences played out over ticks
        base = tracker.commands_taken;
        while (tracker.commands_taken - base < RANDOM_COMMANDS)
        begin
            r = int'($urandom_range(0, 99));
            if ($urandom_range(0, 3) == 0)
                sender_eager = !sender_eager;
            if (r < 6)
            begin
                // Disabled phase: silence, then ignored commands, then back on
                wait_for_drain();
                write_enable(1'b0);
                repeat ($urandom_range(2, 6)) send_item(random_noise());
                wait_for_drain();
                write_enable(1'b1);
            end
            else if (r < 10)
                wait_for_drain();
            else if (r < 60)
            begin
                send_item(make_item(ACT_ENTRY, pick_freq(), pick_duration(), 1'b1));
                n = int'($urandom_range(0, 5));
                repeat (n)
                begin
                    if ($urandom_range(0, 9) < 3)
                        send_item(random_tick());
                    send_item(make_item(ACT_ENTRY, pick_freq(), pick_duration(), 1'b0));
                end
                // Often play the whole sequence out, sometimes cut it short
                if ($urandom_range(0, 3) == 0)
                    send_ticks(int'($urandom_range(0, 40)));
                else
                    send_ticks(int'($urandom_range(60, 220)));
            end
            else if (r < 75)
            begin
                send_item(make_item(ACT_TONE, pick_freq(), pick_duration(), 1'($urandom)));
                send_ticks(int'($urandom_range(0, 60)));
            end
            else if (r < 85)
            begin
                // Stray later entry wherever the sequence happens to be
                send_item(make_item(ACT_ENTRY, pick_freq(), pick_duration(), 1'b0));
                send_ticks(int'($urandom_range(0, 5)));
            end
            else
                repeat ($urandom_range(1, 6)) send_item(random_noise());
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands: %0d ticks, %0d single tones, %0d entries, %0d ignored",
                 tracker.commands_taken, tracker.ticks, tracker.single_tones,
                 tracker.entries, tracker.ignored_items);
        $display("%0d queued tones started after a gap, %0d results checked, %0d mismatches",
                 tracker.gap_starts, tracker.results_checked, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("PASS tone_sequence_player_unit");
        else
            $display("FAIL tone_sequence_player_unit");
        $finish;
    end

endmodule
